[rtl/core/wpps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wpps_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int ID_W     = 16;
    localparam int PROB_W   = 17;
    localparam int RND_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SCALE_W  = 20;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = PROB_W + SCALE_W;
    localparam int WGT_W    = PROD_W - FRAC_W;
    localparam int STEP_W   = $clog2(RND_W + 1);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   entry_id;
        logic [PROB_W-1:0] probability;
        logic [RND_W-1:0]  random_value;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]     picked_id;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

[rtl/core/wpps_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/wpps_moddiv.sv]
`timescale 1ns / 1ps
`default_nettype none

module wpps_moddiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wpps_pkg::t_div_req i_req,
    output wpps_pkg::t_div_rsp     o_rsp
);

    import wpps_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [RND_W-1:0]  r_dvd;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_dvd[RND_W-1]};
        diff  = trial - {1'b0, i_req.divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(RND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= diff[SUM_W] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

[rtl/core/weighted_pick_prefix_search_top.sv]
// Weighted random pick over a table of prefix sums.
// Input channel: drive i_word and raise start; the word is taken at a rising
// edge with start high and busy low. busy stays high while a word is at work.
// Result channel: o_done is high for exactly one cycle with o_word valid; the
// receiver takes it then and cannot stall it.
// Config: i_cfg_we with i_cfg_wdata writes weight_scale; write only when idle.
// Steps from accept to o_done:
//   clear, unused kind, full-table append, draw on empty/zero total: o_done
//   registered straight from the idle decision;
//   append: registered multiply, then add and memory write;
//   draw: the one-bit-per-cycle remainder unit, then the binary search, one
//   prefix memory read and compare per step, then the id memory read.
// One word at a time: the next start is taken at the first edge with busy low.
// Reset clears the entry count and total and restores weight_scale to 1000;
// the id and prefix memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module weighted_pick_prefix_search_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire wpps_pkg::t_in_word            i_word,
    output logic                               o_done,
    output wpps_pkg::t_out_word                o_word,
    input  wire logic                          i_cfg_we,
    input  wire logic [wpps_pkg::SCALE_W-1:0]  i_cfg_wdata
);

    import wpps_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_APPEND  = 6'b000010,
        S_DIVIDE  = 6'b000100,
        S_ISSUE   = 6'b001000,
        S_COMPARE = 6'b010000,
        S_FETCH   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [SCALE_W-1:0] r_scale;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SUM_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [PROD_W-1:0]  r_prod;
    logic [ID_W-1:0]    r_eid;
    logic               r_done, n_done;
    t_out_word          r_out, n_out;

    logic               accept;
    logic [SUM_W:0]     sum;
    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   pick;
    logic               ram_we;
    logic [SUM_W-1:0]   prefix_rdata;
    logic [ID_W-1:0]    id_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign sum    = {1'b0, r_total} + (SUM_W + 1)'(r_prod[PROD_W-1:FRAC_W]);
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign pick   = (r_lo >= r_count) ? (r_count - CNT_W'(1)) : r_lo;
    assign ram_we = (r_state == S_APPEND) && !sum[SUM_W];

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_total          = r_total;
        n_lo             = r_lo;
        n_hi             = r_hi;
        n_done           = 1'b0;
        n_out            = r_out;
        div_req.start    = 1'b0;
        div_req.dividend = i_word.random_value;
        div_req.divisor  = r_total;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out.picked_id = '0;
                    n_out.status    = ST_OK;
                    case (i_word.kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                            n_done  = 1'b1;
                        end
                        KIND_APPEND: begin
                            if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                n_out.status = ST_FULL;
                                n_done       = 1'b1;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        KIND_DRAW: begin
                            if (r_count == '0 || r_total == '0) begin
                                n_out.status = ST_ZERO_TOTAL;
                                n_done       = 1'b1;
                            end else begin
                                div_req.start = 1'b1;
                                n_lo          = '0;
                                n_hi          = r_count;
                                n_state       = S_DIVIDE;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_APPEND: begin
                if (sum[SUM_W]) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_total = sum[SUM_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_state = (r_lo < r_hi) ? S_COMPARE : S_FETCH;
            end
            S_COMPARE: begin
                if (prefix_rdata > div_rsp.remainder) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + CNT_W'(1);
                end
                n_state = S_ISSUE;
            end
            S_FETCH: begin
                n_out.picked_id = id_rdata;
                n_done          = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_scale <= SCALE_RESET;
            r_count <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_out <= n_out;
        if (accept) begin
            r_prod <= PROD_W'(i_word.probability) * PROD_W'(r_scale);
            r_eid  <= i_word.entry_id;
        end
    end

    wpps_moddiv u_moddiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    wpps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (sum[SUM_W-1:0]),
        .i_raddr (mid[ADDR_W-1:0]),
        .o_rdata (prefix_rdata)
    );

    wpps_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_ENTRIES)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_eid),
        .i_raddr (pick[ADDR_W-1:0]),
        .o_rdata (id_rdata)
    );

    assign o_done = r_done;
    assign o_word = r_out;

`ifndef ASSERT_OFF
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted word produced neither result nor work");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < CNT_W'(MAX_ENTRIES)))
        else $error("table write past last entry");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMPARE) |-> ((r_lo < r_hi) && (r_hi <= r_count)))
        else $error("search window out of bounds");

    a_error_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.status != ST_OK) |-> (o_word.picked_id == '0))
        else $error("error result carries nonzero id");

    a_div_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVIDE))
        else $error("remainder finished outside a draw");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import wpps_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int WORD_TARGET = 1300;

    typedef enum logic [1:0] {ACT_WORD, ACT_SCALE, ACT_DRAIN} t_act;

    typedef struct {
        t_act               act;
        t_in_word           word;
        logic [SCALE_W-1:0] scale;
    } t_plan_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_in_word           i_word = '0;
    logic               o_done;
    t_out_word          o_word;
    logic               i_cfg_we = 1'b0;
    logic [SCALE_W-1:0] i_cfg_wdata = '0;

    weighted_pick_prefix_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_done      (o_done),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_plan_step word_plan[$];
    t_out_word  pending_picks[$];
    int         err_count = 0;
    int         cycle_count = 0;
    logic       word_taken = 1'b0;

    // table mirror
    logic [ID_W-1:0]    tab_id [MAX_ENTRIES];
    logic [SUM_W-1:0]   tab_sum [MAX_ENTRIES];
    int                 tab_count = 0;
    logic [SUM_W-1:0]   tab_total = '0;
    logic [SCALE_W-1:0] cur_scale = SCALE_RESET;

    function automatic t_out_word predict_pick(t_in_word w);
        t_out_word   res;
        logic [63:0] wgt;
        logic [63:0] sum;
        logic [31:0] rem;
        int          lo;
        int          hi;
        int          mid;
        res = '0;
        case (w.kind)
            KIND_CLEAR: begin
                tab_count = 0;
                tab_total = '0;
            end
            KIND_APPEND: begin
                wgt = (64'(w.probability) * 64'(cur_scale)) >> FRAC_W;
                sum = 64'(tab_total) + wgt;
                if (tab_count >= MAX_ENTRIES || sum > 64'hFFFF_FFFF) begin
                    res.status = ST_FULL;
                end else begin
                    tab_id[tab_count] = w.entry_id;
                    tab_sum[tab_count] = sum[31:0];
                    tab_total = sum[31:0];
                    tab_count++;
                end
            end
            KIND_DRAW: begin
                if (tab_count == 0 || tab_total == 0) begin
                    res.status = ST_ZERO_TOTAL;
                end else begin
                    rem = 32'(w.random_value) % tab_total;
                    lo = 0;
                    hi = tab_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (tab_sum[mid] > rem)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    if (lo >= tab_count)
                        lo = tab_count - 1;
                    res.picked_id = tab_id[lo];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            tab_count = 0;
            tab_total = '0;
            cur_scale = SCALE_RESET;
            word_taken = 1'b0;
        end else begin
            if (o_done) begin
                if (pending_picks.size() == 0) begin
                    $error("unexpected result word: picked_id %h status %0d",
                           o_word.picked_id, o_word.status);
                    err_count++;
                end else begin
                    want = pending_picks.pop_front();
                    if (o_word.picked_id !== want.picked_id) begin
                        $error("picked_id expected %h actual %h",
                               want.picked_id, o_word.picked_id);
                        err_count++;
                    end
                    if (o_word.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_word.status);
                        err_count++;
                    end
                end
            end
            if (i_cfg_we)
                cur_scale = i_cfg_wdata;
            word_taken = start && !busy;
            if (word_taken)
                pending_picks.insert(pending_picks.size(), predict_pick(i_word));
        end
    end

    always @(negedge i_clk) begin
        logic               nx_start;
        t_in_word           nx_word;
        logic               nx_we;
        logic [SCALE_W-1:0] nx_wdata;
        logic               gaps_on;
        t_plan_step         s;
        nx_start = start;
        nx_word = i_word;
        nx_we = 1'b0;
        nx_wdata = i_cfg_wdata;
        gaps_on = cycle_count < 3000 || cycle_count > 9000;
        if (!i_rst_n) begin
            nx_start = 1'b0;
        end else if (!start || word_taken) begin
            nx_start = 1'b0;
            if (word_plan.size() > 0 && !(gaps_on && $urandom_range(0, 99) < 7)) begin
                s = word_plan[0];
                case (s.act)
                    ACT_WORD: begin
                        nx_start = 1'b1;
                        nx_word = s.word;
                        void'(word_plan.pop_front());
                    end
                    ACT_SCALE: begin
                        if (pending_picks.size() == 0 && !busy) begin
                            nx_we = 1'b1;
                            nx_wdata = s.scale;
                            void'(word_plan.pop_front());
                        end
                    end
                    default: begin
                        if (pending_picks.size() == 0)
                            void'(word_plan.pop_front());
                    end
                endcase
            end
        end
        start <= nx_start;
        i_word <= nx_word;
        i_cfg_we <= nx_we;
        i_cfg_wdata <= nx_wdata;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add_word(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                            logic [PROB_W-1:0] prob, logic [RND_W-1:0] rnd);
        t_plan_step s;
        s.act = ACT_WORD;
        s.word.kind = kind;
        s.word.entry_id = id;
        s.word.probability = prob;
        s.word.random_value = rnd;
        s.scale = '0;
        word_plan.insert(word_plan.size(), s);
    endtask

    task automatic add_scale(logic [SCALE_W-1:0] v);
        t_plan_step s;
        s.act = ACT_SCALE;
        s.word = '0;
        s.scale = v;
        word_plan.insert(word_plan.size(), s);
    endtask

    task automatic add_drain();
        t_plan_step s;
        s.act = ACT_DRAIN;
        s.word = '0;
        s.scale = '0;
        word_plan.insert(word_plan.size(), s);
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 15)
            return PROB_W'($urandom_range(65537, 131071));
        if (r < 20)
            return PROB_W'(65536);
        return PROB_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [RND_W-1:0] rand_rnd();
        if ($urandom_range(0, 3) == 0)
            return RND_W'($urandom_range(0, 4095));
        return RND_W'($urandom());
    endfunction

    initial begin
        logic [SCALE_W-1:0] scales[9];
        int                 n_words;
        int                 phase;
        int                 len;
        int                 r;
        logic               fill;
        scales = '{20'd1000, 20'd1, 20'd10, 20'd100, 20'd10000, 20'd100000,
                   20'd1000000, 20'hFFFFF, 20'd0};

        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd5);
        add_word(KIND_UNUSED, 16'($urandom()), 17'h1FFFF, 31'h7FFFFFFF);
        add_word(KIND_APPEND, 16'hFFFF, 17'h00000, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd12);
        add_word(KIND_APPEND, 16'h0000, 17'h10000, 31'd0);
        add_word(KIND_APPEND, 16'h1234, 17'h00000, 31'd0);
        add_word(KIND_APPEND, 16'hABCD, 17'h1FFFF, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd999);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd1000);
        add_word(KIND_DRAW, 16'hFFFF, 17'h1FFFF, 31'h7FFFFFFF);
        add_word(KIND_CLEAR, 16'hFFFF, 17'h1FFFF, 31'h7FFFFFFF);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd77);
        add_scale(20'd0);
        add_word(KIND_APPEND, 16'h0F0F, 17'h10000, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd3);
        add_scale(20'hFFFFF);
        add_word(KIND_CLEAR, 16'h0000, 17'h00000, 31'd0);
        add_word(KIND_APPEND, 16'h5555, 17'h1FFFF, 31'd0);
        add_word(KIND_APPEND, 16'hAAAA, 17'h00001, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'h7FFFFFFF);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd0);
        add_drain();
        add_scale(20'd1);
        add_word(KIND_CLEAR, 16'h0000, 17'h00000, 31'd0);
        add_word(KIND_APPEND, 16'h00FF, 17'h10000, 31'd0);
        add_word(KIND_DRAW, 16'h0000, 17'h00000, 31'd9);

        n_words = 0;
        phase = 0;
        while (n_words < WORD_TARGET) begin
            if (phase < 9)
                add_scale(scales[phase]);
            else
                add_scale(scales[$urandom_range(0, 8)]);
            add_word(KIND_CLEAR, 16'($urandom()), rand_prob(), rand_rnd());
            fill = (phase == 6) || ($urandom_range(0, 19) == 0);
            len = fill ? 330 : $urandom_range(8, 40);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (fill) begin
                    if (r < 85)
                        add_word(KIND_APPEND, 16'($urandom()), rand_prob(), rand_rnd());
                    else
                        add_word(KIND_DRAW, 16'($urandom()), rand_prob(), rand_rnd());
                    n_words++;
                end else if (r < 45) begin
                    add_word(KIND_APPEND, 16'($urandom()), rand_prob(), rand_rnd());
                    n_words++;
                end else if (r < 90) begin
                    add_word(KIND_DRAW, 16'($urandom()), rand_prob(), rand_rnd());
                    n_words++;
                end else if (r < 94) begin
                    add_word(KIND_CLEAR, 16'($urandom()), rand_prob(), rand_rnd());
                    n_words++;
                end else if (r < 97) begin
                    add_word(KIND_UNUSED, 16'($urandom()), rand_prob(), rand_rnd());
                end else begin
                    add_drain();
                end
            end
            phase++;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // hold until the plan is consumed and every word has its result
        while (word_plan.size() != 0 || start || pending_picks.size() != 0)
            @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/wpps_pkg.sv
rtl/core/wpps_ram.sv
rtl/core/wpps_moddiv.sv
rtl/core/weighted_pick_prefix_search_top.sv
sim/tb.sv
